FILE: rtl/vrst_pkg.sv
`timescale 1ns / 1ps
package vrst_pkg;

  // default geometry
  localparam int NAMETABLE_BYTES_DEF = 4096;
  localparam int PATTERN_BYTES_DEF   = 8192;
  localparam int DOTS_PER_LINE_DEF   = 341;
  localparam int LINES_PER_FRAME_DEF = 262;

  localparam int CNT_W = 9;

  // item operations
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_ACK   = 2'd3;

  // register numbers
  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_MASK   = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_OAMADR = 3'd3;
  localparam logic [2:0] REG_OAMDAT = 3'd4;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR   = 3'd6;
  localparam logic [2:0] REG_DATA   = 3'd7;

  // mirroring modes
  localparam logic [1:0] MIR_HORZ = 2'd0;
  localparam logic [1:0] MIR_VERT = 2'd1;

  // pending source of the read buffer
  typedef enum logic [1:0] {
    BUF_NONE = 2'd0,
    BUF_PAT  = 2'd1,
    BUF_NT   = 2'd2
  } buf_src_t;

  // timing unit to register core
  typedef struct packed {
    logic [CNT_W-1:0] dot_q;
    logic [CNT_W-1:0] line_q;
    logic             parity_q;
    logic [CNT_W-1:0] dot_nxt;
    logic [CNT_W-1:0] line_nxt;
    logic             parity_nxt;
    logic             yinc;
    logic             hcopy;
    logic             vcopy;
    logic             set_vbl;
    logic             clr_status;
  } tm_t;

endpackage

FILE: rtl/video_register_scroll_timing_unit.sv
`timescale 1ns / 1ps
// Scroll, timing and CPU register unit of a tile video processor. Each input
// word is a dot tick, a register read, a register write or an NMI acknowledge,
// and each gives one result word. One word is accepted per clock while
// in_stall is low; it is high during the zero sweep of the memories after reset
// and while the result stage and output register are full with out_stall high.
// A result passes the result stage (synchronous pattern, nametable or sprite
// read) and then the output register. mirror_mode writes are taken at any time
// through the cfg port, which is always ready.
module video_register_scroll_timing_unit #(
  parameter int NAMETABLE_BYTES = vrst_pkg::NAMETABLE_BYTES_DEF,
  parameter int PATTERN_BYTES   = vrst_pkg::PATTERN_BYTES_DEF,
  parameter int DOTS_PER_LINE   = vrst_pkg::DOTS_PER_LINE_DEF,
  parameter int LINES_PER_FRAME = vrst_pkg::LINES_PER_FRAME_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_op,
  input  logic [2:0] in_reg_req,
  input  logic [7:0] in_wdata,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_rdata,
  output logic       out_nmi_pending,
  output logic [8:0] out_line_now,
  output logic [8:0] out_dot_now,
  output logic       out_odd_frame,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_mirror_mode
);

  localparam int NT_AW  = $clog2(NAMETABLE_BYTES);
  localparam int PAT_AW = $clog2(PATTERN_BYTES);
  localparam logic [12:0] NT_SIZE  = 13'(NAMETABLE_BYTES);
  localparam logic [PAT_AW-1:0] CLR_LAST = PAT_AW'(PATTERN_BYTES - 1);

  // mirroring and palette address folding
  function automatic logic [NT_AW-1:0] nt_index(input logic [1:0] mode,
                                               input logic [13:0] a);
    logic [12:0] x;
    logic [12:0] y;
    begin
      x = {1'b0, a[11:0]};
      if (mode == vrst_pkg::MIR_HORZ) begin
        x = {2'b0, a[11], a[9:0]};
      end else if (mode == vrst_pkg::MIR_VERT) begin
        x = {2'b0, a[10:0]};
      end
      y = (x >= NT_SIZE) ? x - NT_SIZE : x;
      nt_index = y[NT_AW-1:0];
    end
  endfunction

  function automatic logic [4:0] pal_index(input logic [13:0] a);
    logic [4:0] i;
    begin
      i = a[4:0];
      if (i[4] && i[1:0] == 2'b00) begin
        i[4] = 1'b0;
      end
      pal_index = i;
    end
  endfunction

  function automatic logic [15:0] step_y(input logic [15:0] v);
    logic [15:0] r;
    logic [4:0]  cy;
    begin
      r = v;
      if (v[14:12] != 3'b111) begin
        r = v + 16'h1000;
      end else begin
        r[14:12] = 3'b000;
        cy = r[9:5];
        if (cy == 5'd29) begin
          cy = 5'd0;
          r[11] = ~r[11];
        end else if (cy == 5'd31) begin
          cy = 5'd0;
        end else begin
          cy = cy + 5'd1;
        end
        r[9:5] = cy;
      end
      step_y = r;
    end
  endfunction

  // state registers
  logic [1:0]  mirror_r;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic [2:0]  stat_r, stat_nxt;
  logic [7:0]  oam_r, oam_nxt;
  logic [15:0] cur_r, cur_nxt;
  logic [14:0] lat_r, lat_nxt;
  logic [2:0]  finex_r, finex_nxt;
  logic        w_r, w_nxt;
  logic [7:0]  dbuf_r, dbuf_nxt;
  logic [7:0]  blat_r, blat_nxt;
  logic        nmi_r, nmi_nxt;
  vrst_pkg::buf_src_t dpend_r, dpend_nxt;
  logic        bpend_r, bpend_nxt;
  logic [5:0]  pal_r [32];

  // clearing sweep
  logic              clr_r;
  logic [PAT_AW-1:0] clr_cnt_r;

  // pipeline
  logic       s1_v_r, s1_spr_r;
  logic [7:0] s1_rd_r;
  logic       s1_nmi_r, s1_par_r;
  logic [8:0] s1_line_r, s1_dot_r;
  logic       out_v_r;
  logic [7:0] out_rd_r;
  logic       out_nmi_r, out_par_r;
  logic [8:0] out_line_r, out_dot_r;

  logic       acc, s1_move;
  logic [7:0] rd;
  logic       rd_spr;
  logic [7:0] dbuf_eff, blat_eff;
  logic [13:0] a14;
  logic [15:0] inc;

  // memory ports
  logic              pat_we, pat_re;
  logic [PAT_AW-1:0] pat_wa, pat_ra;
  logic [7:0]        pat_wd, pat_q;
  logic              nt_we, nt_re;
  logic [NT_AW-1:0]  nt_wa, nt_ra;
  logic [7:0]        nt_wd, nt_q;
  logic              spr_we, spr_re;
  logic [7:0]        spr_wa, spr_wd, spr_q;
  logic              pal_we;
  logic [4:0]        pal_wa;

  vrst_pkg::tm_t tm;

  assign cfg_ready = 1'b1;
  assign in_stall  = clr_r || (s1_v_r && out_v_r && out_stall);
  assign acc       = in_valid && !in_stall;
  assign s1_move   = s1_v_r && (!out_v_r || !out_stall);

  vrst_timing #(
    .DOTS_PER_LINE   (DOTS_PER_LINE),
    .LINES_PER_FRAME (LINES_PER_FRAME)
  ) u_timing (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick      (acc && in_op == vrst_pkg::OP_TICK),
    .rendering (mask_r[4] || mask_r[3]),
    .tm        (tm)
  );

  // forwarded values still in flight from memory
  assign dbuf_eff = (dpend_r == vrst_pkg::BUF_PAT) ? pat_q :
                    (dpend_r == vrst_pkg::BUF_NT) ? nt_q : dbuf_r;
  assign blat_eff = bpend_r ? spr_q : blat_r;
  assign a14      = cur_r[13:0];
  assign inc      = ctrl_r[2] ? 16'd32 : 16'd1;

  // item processing
  always_comb begin
    ctrl_nxt  = ctrl_r;
    mask_nxt  = mask_r;
    stat_nxt  = stat_r;
    oam_nxt   = oam_r;
    cur_nxt   = cur_r;
    lat_nxt   = lat_r;
    finex_nxt = finex_r;
    w_nxt     = w_r;
    dbuf_nxt  = dbuf_eff;
    blat_nxt  = blat_eff;
    nmi_nxt   = nmi_r;
    dpend_nxt = vrst_pkg::BUF_NONE;
    bpend_nxt = 1'b0;
    rd        = 8'd0;
    rd_spr    = 1'b0;
    pat_re = 1'b0; pat_ra = a14[PAT_AW-1:0];
    nt_re  = 1'b0; nt_ra  = nt_index(mirror_r, a14);
    spr_re = 1'b0;
    pat_we = 1'b0; pat_wa = a14[PAT_AW-1:0]; pat_wd = in_wdata;
    nt_we  = 1'b0; nt_wa  = nt_index(mirror_r, a14); nt_wd = in_wdata;
    spr_we = 1'b0; spr_wa = oam_r; spr_wd = in_wdata;
    pal_we = 1'b0; pal_wa = pal_index(a14);
    if (acc) begin
      unique case (in_op)
        vrst_pkg::OP_TICK: begin
          if (tm.yinc) begin
            cur_nxt = step_y(cur_r);
          end else if (tm.hcopy) begin
            cur_nxt = (cur_r & ~16'h041F) | ({1'b0, lat_r} & 16'h041F);
          end else if (tm.vcopy) begin
            cur_nxt = (cur_r & ~16'h7BE0) | ({1'b0, lat_r} & 16'h7BE0);
          end
          if (tm.set_vbl) begin
            stat_nxt[2] = 1'b1;
            if (ctrl_r[7]) begin
              nmi_nxt = 1'b1;
            end
          end else if (tm.clr_status) begin
            stat_nxt = 3'b000;
          end
        end
        vrst_pkg::OP_READ: begin
          unique case (in_reg_req)
            vrst_pkg::REG_STATUS: begin
              rd          = {stat_r, blat_eff[4:0]};
              stat_nxt[2] = 1'b0;
              w_nxt       = 1'b0;
              blat_nxt    = rd;
            end
            vrst_pkg::REG_OAMDAT: begin
              spr_re    = 1'b1;
              rd_spr    = 1'b1;
              bpend_nxt = 1'b1;
            end
            vrst_pkg::REG_DATA: begin
              if (a14 >= 14'h3F00) begin
                rd        = {2'b00, pal_r[pal_index(a14)]};
                nt_re     = 1'b1;
                dpend_nxt = vrst_pkg::BUF_NT;
              end else begin
                rd = dbuf_eff;
                if (a14 < 14'h2000) begin
                  pat_re    = 1'b1;
                  dpend_nxt = vrst_pkg::BUF_PAT;
                end else begin
                  nt_re     = 1'b1;
                  dpend_nxt = vrst_pkg::BUF_NT;
                end
              end
              cur_nxt  = cur_r + inc;
              blat_nxt = rd;
            end
            default: begin
              rd = blat_eff;
            end
          endcase
        end
        vrst_pkg::OP_WRITE: begin
          blat_nxt = in_wdata;
          unique case (in_reg_req)
            vrst_pkg::REG_CTRL: begin
              if (!ctrl_r[7] && in_wdata[7] && stat_r[2]) begin
                nmi_nxt = 1'b1;
              end
              ctrl_nxt       = in_wdata;
              lat_nxt[11:10] = in_wdata[1:0];
            end
            vrst_pkg::REG_MASK: begin
              mask_nxt = in_wdata;
            end
            vrst_pkg::REG_OAMADR: begin
              oam_nxt = in_wdata;
            end
            vrst_pkg::REG_OAMDAT: begin
              spr_we  = 1'b1;
              oam_nxt = oam_r + 8'd1;
            end
            vrst_pkg::REG_SCROLL: begin
              if (!w_r) begin
                finex_nxt    = in_wdata[2:0];
                lat_nxt[4:0] = in_wdata[7:3];
              end else begin
                lat_nxt[14:12] = in_wdata[2:0];
                lat_nxt[9:5]   = in_wdata[7:3];
              end
              w_nxt = ~w_r;
            end
            vrst_pkg::REG_ADDR: begin
              if (!w_r) begin
                lat_nxt[14:8] = {1'b0, in_wdata[5:0]};
              end else begin
                lat_nxt[7:0] = in_wdata;
                cur_nxt      = {1'b0, lat_r[14:8], in_wdata};
              end
              w_nxt = ~w_r;
            end
            vrst_pkg::REG_DATA: begin
              if (a14 < 14'h2000) begin
                pat_we = 1'b1;
              end else if (a14 < 14'h3F00) begin
                nt_we = 1'b1;
              end else begin
                pal_we = 1'b1;
              end
              cur_nxt = cur_r + inc;
            end
            default: begin
            end
          endcase
        end
        vrst_pkg::OP_ACK: begin
          rd      = {7'd0, nmi_r};
          nmi_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
    // zero sweep after reset
    if (clr_r) begin
      pat_we = 1'b1;
      pat_wa = clr_cnt_r;
      pat_wd = 8'd0;
      nt_we  = ({1'b0, clr_cnt_r} < (PAT_AW+1)'(NAMETABLE_BYTES));
      nt_wa  = clr_cnt_r[NT_AW-1:0];
      nt_wd  = 8'd0;
      spr_we = ({1'b0, clr_cnt_r} < (PAT_AW+1)'(256));
      spr_wa = clr_cnt_r[7:0];
      spr_wd = 8'd0;
    end
  end

  vrst_ram #(.WIDTH(8), .DEPTH(PATTERN_BYTES)) u_pat_ram (
    .clk (clk), .we (pat_we), .waddr (pat_wa), .wdata (pat_wd),
    .re (pat_re), .raddr (pat_ra), .rdata (pat_q)
  );

  vrst_ram #(.WIDTH(8), .DEPTH(NAMETABLE_BYTES)) u_nt_ram (
    .clk (clk), .we (nt_we), .waddr (nt_wa), .wdata (nt_wd),
    .re (nt_re), .raddr (nt_ra), .rdata (nt_q)
  );

  vrst_ram #(.WIDTH(8), .DEPTH(256)) u_spr_ram (
    .clk (clk), .we (spr_we), .waddr (spr_wa), .wdata (spr_wd),
    .re (spr_re), .raddr (oam_r), .rdata (spr_q)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_r  <= 2'd0;
      ctrl_r    <= '0;
      mask_r    <= '0;
      stat_r    <= '0;
      oam_r     <= '0;
      cur_r     <= '0;
      lat_r     <= '0;
      finex_r   <= '0;
      w_r       <= 1'b0;
      dbuf_r    <= '0;
      blat_r    <= '0;
      nmi_r     <= 1'b0;
      dpend_r   <= vrst_pkg::BUF_NONE;
      bpend_r   <= 1'b0;
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
      for (int i = 0; i < 32; i++) begin
        pal_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        mirror_r <= cfg_mirror_mode;
      end
      ctrl_r  <= ctrl_nxt;
      mask_r  <= mask_nxt;
      stat_r  <= stat_nxt;
      oam_r   <= oam_nxt;
      cur_r   <= cur_nxt;
      lat_r   <= lat_nxt;
      finex_r <= finex_nxt;
      w_r     <= w_nxt;
      dbuf_r  <= dbuf_nxt;
      blat_r  <= blat_nxt;
      nmi_r   <= nmi_nxt;
      dpend_r <= dpend_nxt;
      bpend_r <= bpend_nxt;
      if (pal_we) begin
        pal_r[pal_wa] <= in_wdata[5:0];
      end
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_LAST) begin
          clr_r <= 1'b0;
        end
      end
    end
  end

  // result stage and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_move) begin
        s1_v_r <= 1'b0;
      end
      if (s1_move) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_rd_r   <= rd;
      s1_spr_r  <= rd_spr;
      s1_nmi_r  <= nmi_nxt;
      s1_line_r <= (in_op == vrst_pkg::OP_TICK) ? tm.line_nxt : tm.line_q;
      s1_dot_r  <= (in_op == vrst_pkg::OP_TICK) ? tm.dot_nxt : tm.dot_q;
      s1_par_r  <= (in_op == vrst_pkg::OP_TICK) ? tm.parity_nxt : tm.parity_q;
    end
    if (s1_move) begin
      out_rd_r   <= s1_spr_r ? spr_q : s1_rd_r;
      out_nmi_r  <= s1_nmi_r;
      out_line_r <= s1_line_r;
      out_dot_r  <= s1_dot_r;
      out_par_r  <= s1_par_r;
    end
  end

  assign out_valid       = out_v_r;
  assign out_rdata       = out_rd_r;
  assign out_nmi_pending = out_nmi_r;
  assign out_line_now    = out_line_r;
  assign out_dot_now     = out_dot_r;
  assign out_odd_frame   = out_par_r;

endmodule

FILE: rtl/vrst_ram.sv
`timescale 1ns / 1ps
module vrst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/vrst_timing.sv
`timescale 1ns / 1ps
module vrst_timing #(
  parameter int DOTS_PER_LINE   = vrst_pkg::DOTS_PER_LINE_DEF,
  parameter int LINES_PER_FRAME = vrst_pkg::LINES_PER_FRAME_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          tick,
  input  logic          rendering,
  output vrst_pkg::tm_t tm
);

  localparam int W = vrst_pkg::CNT_W;
  localparam logic [W-1:0] LAST_DOT = W'(DOTS_PER_LINE - 1);
  localparam logic [W-1:0] PRE_LINE = W'(LINES_PER_FRAME - 1);
  localparam logic [W:0]   DPL      = (W+1)'(DOTS_PER_LINE);
  localparam logic [W:0]   LPF      = (W+1)'(LINES_PER_FRAME);

  logic [W-1:0] dot_r, dot_nxt;
  logic [W-1:0] line_r, line_nxt;
  logic         par_r, par_nxt;
  logic [W:0]   d1, l1;
  logic         pre, active;

  // dot and line advance with odd-frame skip
  always_comb begin
    d1 = {1'b0, dot_r} + 1'b1;
    l1 = {1'b0, line_r} + 1'b1;
    dot_nxt  = d1[W-1:0];
    line_nxt = line_r;
    par_nxt  = par_r;
    if (line_r == PRE_LINE && d1 == {1'b0, LAST_DOT} && par_r && rendering) begin
      dot_nxt  = '0;
      line_nxt = '0;
      par_nxt  = ~par_r;
    end else if (d1 >= DPL) begin
      dot_nxt = '0;
      if (l1 >= LPF) begin
        line_nxt = '0;
        par_nxt  = ~par_r;
      end else begin
        line_nxt = l1[W-1:0];
      end
    end
  end

  // scroll and vblank events at the new position
  always_comb begin
    pre    = (line_nxt == PRE_LINE);
    active = rendering && ((line_nxt < W'(240)) || pre);
    tm.dot_q      = dot_r;
    tm.line_q     = line_r;
    tm.parity_q   = par_r;
    tm.dot_nxt    = dot_nxt;
    tm.line_nxt   = line_nxt;
    tm.parity_nxt = par_nxt;
    tm.yinc       = active && dot_nxt == W'(256);
    tm.hcopy      = active && dot_nxt == W'(257);
    tm.vcopy      = active && pre && dot_nxt >= W'(280) && dot_nxt <= W'(304);
    tm.set_vbl    = dot_nxt == W'(1) && line_nxt == W'(241);
    tm.clr_status = dot_nxt == W'(1) && pre;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r  <= '0;
      line_r <= '0;
      par_r  <= 1'b0;
    end else if (tick) begin
      dot_r  <= dot_nxt;
      line_r <= line_nxt;
      par_r  <= par_nxt;
    end
  end

endmodule
